// ===== hw/rtl/nlpd_pkg.sv =====
// Shared constants for the nonlinear PD steering controller: config register
// indexes, reset values, fixed-point defaults and the radix-16 divide-by-5 digit step.
// No dependencies.
`timescale 1ns / 1ps

package nlpd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int BIG_LOG       = 57;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_P_DIVISOR       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURVATURE_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURVATURE_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURVATURE_PARAM = 3'd6;

    localparam logic [15:0] RST_P_DIVISOR       = 16'd300;
    localparam logic [15:0] RST_I_GAIN          = 16'd0;
    localparam logic [15:0] RST_D_GAIN          = 16'd0;
    localparam logic [15:0] RST_COEFF           = 16'd10000;
    localparam logic [14:0] RST_CURVATURE_LIMIT = 15'd480;
    localparam logic [14:0] RST_CURVATURE_MIN   = 15'd335;
    localparam logic [15:0] RST_CURVATURE_PARAM = 16'd300;

    // x < 80: quotient digit by reciprocal multiply, then remainder
    function automatic logic [6:0] div5_step(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  qx5;
        logic [6:0]  r;
        prod = 15'(x) * 15'd205;
        q    = prod[13:10];
        qx5  = {1'b0, q, 2'b00} + {3'b000, q};
        r    = x - qx5;
        return {q, r[2:0]};
    endfunction

endpackage

// ===== hw/rtl/nonlinear_pd_steering_speed_limit.sv =====
// Top level of the nonlinear PD steering controller with speed dependent limit.
// Uses nlpd_pkg; one shared shift/add/subtract datapath under a state sequencer.
//
//   channel   direction   handshake                 payload
//   in        sink        i_in_valid / o_in_stall   i_reference, i_feedback, i_speed,
//                                                   i_derivative_off
//   out       source      o_out_valid / i_out_stall o_drive, o_limited
//   cfg       sink        i_cfg_we                  i_cfg_idx, i_cfg_data
//
// An item passes through the radix-2 divide of e*e, two 16-step shift-add
// multiplies, the radix-16 divide by five and the 20-step limit divide. The
// first item after reset or after a write to i_gain, d_gain or coeff first
// computes the gain quotients.
// o_in_stall is high while an item is in work. A stalled result holds the
// output register; the next item is taken once the result is loaded there.
`timescale 1ns / 1ps

module nonlinear_pd_steering_speed_limit
    import nlpd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_reference,
    input  logic signed [15:0]    i_feedback,
    input  logic [9:0]            i_speed,
    input  logic                  i_derivative_off,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_drive,
    output logic                  o_limited,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int KW     = 16 + FRAC_BITS;
    localparam int QW     = 31 + FRAC_BITS;
    localparam int NW     = ((34 + FRAC_BITS + 3) / 4) * 4;
    localparam int PW     = (47 + FRAC_BITS > BIG_LOG + 1) ? 47 + FRAC_BITS : BIG_LOG + 1;
    localparam int SW     = PW + 2;
    localparam int CW     = $clog2(NW + 1);
    localparam int DIGITS = NW / 4;
    localparam logic [PW-1:0] BIG_VAL = PW'(1) << BIG_LOG;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KI    = 4'd1;
    localparam logic [3:0] S_KD    = 4'd2;
    localparam logic [3:0] S_KDW   = 4'd3;
    localparam logic [3:0] S_PREP  = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_KSUM  = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_PSAVE = 4'd9;
    localparam logic [3:0] S_D5    = 4'd10;
    localparam logic [3:0] S_DIV5  = 4'd11;
    localparam logic [3:0] S_LIMQ  = 4'd12;
    localparam logic [3:0] S_LIM   = 4'd13;
    localparam logic [3:0] S_RAW   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [15:0]        r_p_div, r_i_gain, r_d_gain, r_coeff, r_curv_par;
    logic [14:0]        r_curv_lim, r_curv_min;
    logic               r_dirty;
    logic [3:0]         r_state, n_state, r_ret;
    logic [CW-1:0]      r_cnt;
    logic [15:0]        r_prev_err, r_e;
    logic [9:0]         r_speed;
    logic               r_doff;
    logic [15:0]        r_ae, r_ade;
    logic               r_de_neg;
    logic [NW-1:0]      r_num, r_dm;
    logic [15:0]        r_rem, r_div;
    logic [KW-1:0]      r_ki, r_kd;
    logic [PW-1:0]      r_mcand, r_acc, r_pm;
    logic [15:0]        r_mplier;
    logic               r_big;
    logic [14:0]        r_lim;
    logic [SW-1:0]      r_sum;
    logic signed [15:0] r_raw;
    logic               r_out_valid;
    logic signed [15:0] r_drive;
    logic               r_limited;

    logic        accept, out_free;
    logic [16:0] diff, de, de_mag;
    logic [15:0] e_sat, ae, ade;
    logic [15:0] nz_p, nz_c, nz_cp;
    logic [16:0] rs, rs_sub;
    logic        ge;
    logic [6:0]  d5;
    logic [31:0] sq_ae;
    logic [19:0] sq_sp;
    logic [QW-1:0] kp_sum;
    logic [PW-1:0] mul_sum;
    logic [20:0] qc, cl21, lim_diff;
    logic [14:0] lim_a, lim_v;
    logic [SW-1:0] pm_u, pm_s, dm_u, dm_s, mag, q;
    logic [15:0] q_neg;
    logic signed [15:0] raw, lim_s, lim_n;

    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_limited   = r_limited;

    always_comb begin
        diff = {i_reference[15], i_reference} - {i_feedback[15], i_feedback};
        if (diff[16] != diff[15]) begin
            e_sat = diff[16] ? 16'h8000 : 16'h7FFF;
        end else begin
            e_sat = diff[15:0];
        end
        ae     = r_e[15] ? (~r_e + 16'd1) : r_e;
        de     = {r_e[15], r_e} - {r_prev_err[15], r_prev_err};
        de_mag = de[16] ? (~de + 17'd1) : de;
        ade    = de_mag[15:0];

        nz_p  = (r_p_div == 16'd0) ? 16'd1 : r_p_div;
        nz_c  = (r_coeff == 16'd0) ? 16'd1 : r_coeff;
        nz_cp = (r_curv_par == 16'd0) ? 16'd1 : r_curv_par;

        rs     = {r_rem, r_num[NW-1]};
        ge     = (rs >= {1'b0, r_div});
        rs_sub = rs - {1'b0, r_div};
        d5     = div5_step({r_rem[2:0], r_num[NW-1 -: 4]});

        sq_ae   = 32'(r_ae) * 32'(r_ae);
        sq_sp   = 20'(r_speed) * 20'(r_speed);
        kp_sum  = r_num[QW-1:0] + QW'(r_ki);
        mul_sum = r_acc + (r_mplier[0] ? r_mcand : '0);

        qc       = {1'b0, r_num[19:0]} + {20'd0, (r_rem != 16'd0)};
        cl21     = {6'd0, r_curv_lim};
        lim_diff = cl21 - qc;
        lim_a    = (qc <= cl21) ? lim_diff[14:0] : 15'd0;
        lim_v    = (lim_a < r_curv_min) ? r_curv_min : lim_a;

        pm_u = SW'(r_pm);
        pm_s = r_e[15] ? (~pm_u + SW'(1)) : pm_u;
        dm_u = SW'(r_dm);
        dm_s = r_de_neg ? (~dm_u + SW'(1)) : dm_u;

        mag   = r_sum[SW-1] ? (~r_sum + SW'(1)) : r_sum;
        q     = mag >> FRAC_BITS;
        q_neg = ~q[15:0] + 16'd1;
        if (r_big) begin
            raw = r_e[15] ? 16'sh8000 : 16'sh7FFF;
        end else if (!r_sum[SW-1]) begin
            raw = (q > SW'(32767)) ? 16'sh7FFF : $signed(q[15:0]);
        end else begin
            raw = (q > SW'(32768)) ? 16'sh8000 : $signed(q_neg);
        end

        lim_s = $signed({1'b0, r_lim});
        lim_n = -lim_s;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = r_dirty ? S_KI : S_PREP;
            S_KI:    n_state = S_DIV;
            S_KD:    n_state = S_DIV;
            S_KDW:   n_state = S_PREP;
            S_PREP:  n_state = S_SQ;
            S_SQ:    n_state = S_DIV;
            S_DIV:   if (r_cnt == CW'(1)) n_state = r_ret;
            S_KSUM:  n_state = S_MUL;
            S_MUL:   if (r_cnt == CW'(1)) n_state = r_ret;
            S_PSAVE: n_state = S_MUL;
            S_D5:    n_state = S_DIV5;
            S_DIV5:  if (r_cnt == CW'(1)) n_state = S_LIMQ;
            S_LIMQ:  n_state = S_DIV;
            S_LIM:   n_state = S_RAW;
            S_RAW:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= 1'b1;
            r_out_valid <= 1'b0;
            r_prev_err  <= 16'd0;
            r_p_div     <= RST_P_DIVISOR;
            r_i_gain    <= RST_I_GAIN;
            r_d_gain    <= RST_D_GAIN;
            r_coeff     <= RST_COEFF;
            r_curv_lim  <= RST_CURVATURE_LIMIT;
            r_curv_min  <= RST_CURVATURE_MIN;
            r_curv_par  <= RST_CURVATURE_PARAM;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_P_DIVISOR:       r_p_div    <= i_cfg_data;
                    REG_I_GAIN: begin
                        r_i_gain <= i_cfg_data;
                        r_dirty  <= 1'b1;
                    end
                    REG_D_GAIN: begin
                        r_d_gain <= i_cfg_data;
                        r_dirty  <= 1'b1;
                    end
                    REG_COEFF: begin
                        r_coeff <= i_cfg_data;
                        r_dirty <= 1'b1;
                    end
                    REG_CURVATURE_LIMIT: r_curv_lim <= i_cfg_data[14:0];
                    REG_CURVATURE_MIN:   r_curv_min <= i_cfg_data[14:0];
                    REG_CURVATURE_PARAM: r_curv_par <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_e     <= e_sat;
                        r_speed <= i_speed;
                        r_doff  <= i_derivative_off;
                    end
                end
                S_KI: begin
                    r_num <= {r_i_gain, (NW-16)'(0)};
                    r_rem <= 16'd0;
                    r_div <= nz_c;
                    r_cnt <= CW'(KW);
                    r_ret <= S_KD;
                end
                S_KD: begin
                    r_ki  <= r_num[KW-1:0];
                    r_num <= {r_d_gain, (NW-16)'(0)};
                    r_rem <= 16'd0;
                    r_div <= nz_c;
                    r_cnt <= CW'(KW);
                    r_ret <= S_KDW;
                end
                S_KDW: begin
                    r_kd    <= r_num[KW-1:0];
                    r_dirty <= 1'b0;
                end
                S_PREP: begin
                    r_ae       <= ae;
                    r_ade      <= ade;
                    r_de_neg   <= de[16];
                    r_prev_err <= r_e;
                end
                S_SQ: begin
                    r_num <= {sq_ae[30:0], (NW-31)'(0)};
                    r_rem <= 16'd0;
                    r_div <= nz_p;
                    r_cnt <= CW'(QW);
                    r_ret <= S_KSUM;
                end
                S_DIV: begin
                    r_num <= {r_num[NW-2:0], ge};
                    r_rem <= ge ? rs_sub[15:0] : rs[15:0];
                    r_cnt <= r_cnt - CW'(1);
                end
                S_KSUM: begin
                    r_mcand  <= PW'(kp_sum);
                    r_mplier <= r_ae;
                    r_acc    <= '0;
                    r_cnt    <= CW'(16);
                    r_ret    <= S_PSAVE;
                end
                S_MUL: begin
                    r_acc    <= mul_sum;
                    r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[15:1]};
                    r_cnt    <= r_cnt - CW'(1);
                end
                S_PSAVE: begin
                    r_pm     <= r_acc;
                    r_big    <= (r_acc > BIG_VAL);
                    r_mcand  <= r_doff ? '0 : PW'(r_kd);
                    r_mplier <= r_ade;
                    r_acc    <= '0;
                    r_cnt    <= CW'(16);
                    r_ret    <= S_D5;
                end
                S_D5: begin
                    r_num <= NW'({r_acc[KW+15:0], 2'b00});
                    r_rem <= 16'd0;
                    r_cnt <= CW'(DIGITS);
                end
                S_DIV5: begin
                    r_num <= {r_num[NW-5:0], d5[6:3]};
                    r_rem <= {13'd0, d5[2:0]};
                    r_cnt <= r_cnt - CW'(1);
                end
                S_LIMQ: begin
                    r_dm  <= r_num;
                    r_num <= {sq_sp, (NW-20)'(0)};
                    r_rem <= 16'd0;
                    r_div <= nz_cp;
                    r_cnt <= CW'(20);
                    r_ret <= S_LIM;
                end
                S_LIM: begin
                    r_lim <= lim_v;
                    r_sum <= pm_s + dm_s;
                end
                S_RAW: begin
                    r_raw <= raw;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_raw > lim_s) begin
                            r_drive   <= lim_s;
                            r_limited <= 1'b1;
                        end else if (r_raw < lim_n) begin
                            r_drive   <= lim_n;
                            r_limited <= 1'b1;
                        end else begin
                            r_drive   <= r_raw;
                            r_limited <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/nlpd_checker.sv =====
// Port-level checks for the nonlinear PD steering controller, bound to the top level.
// Watches the item handshakes and the result payload; no package dependencies.
`timescale 1ns / 1ps

module nlpd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_drive,
    input logic               o_limited
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_drive) && $stable(o_limited))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before item finished");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

    a_clamp_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_limited |-> o_drive != 16'sh8000)
        else $error("clamped drive outside symmetric limit");

endmodule

bind nonlinear_pd_steering_speed_limit nlpd_checker u_nlpd_checker (.*);
